// ----- rtl/nnds_pkg.sv -----
// shared types and constants of the nearest-neighbour downscaler
package nnds_pkg;

	localparam int DEF_MAX_IN_SIZE = 4096;
	localparam int DEF_FRAC_BITS   = 16;

	localparam int MAX_OUT_WIDTH  = 64;
	localparam int OUT_HEIGHT_MAX = 64;
	localparam int COL_BITS       = 6;
	localparam int ROW_BITS       = 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [2:0] REG_STEP_X     = 3'd0;
	localparam logic [2:0] REG_STEP_Y     = 3'd1;
	localparam logic [2:0] REG_IN_WIDTH   = 3'd2;
	localparam logic [2:0] REG_IN_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_OUT_WIDTH  = 3'd4;
	localparam logic [2:0] REG_OUT_HEIGHT = 3'd5;

	typedef struct packed {
		logic                from_store;
		logic [7:0]          pix;
		logic [COL_BITS-1:0] first_col;
		logic [COL_BITS-1:0] last_col;
		logic [ROW_BITS-1:0] row;
	} cmd_t;

endpackage

// ----- rtl/nnds_front.sv -----
// front part: position accumulators and classification of input transfers
module nnds_front #(
	parameter int MAX_IN_SIZE = nnds_pkg::DEF_MAX_IN_SIZE,
	parameter int FRAC_BITS   = nnds_pkg::DEF_FRAC_BITS,
	localparam int IW = $clog2(MAX_IN_SIZE + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         kind,
	input  logic [7:0]                   pixel_value,
	input  logic [FRAC_BITS:0]           step_x_eff,
	input  logic [FRAC_BITS:0]           step_y_eff,
	input  logic [IW-1:0]                iw,
	input  logic [IW-1:0]                ih,
	input  logic [nnds_pkg::COL_BITS-1:0] wm1,
	input  logic [nnds_pkg::ROW_BITS-1:0] hm1,
	output logic                         push,
	output nnds_pkg::cmd_t               cmd
);

	localparam int PW = IW + FRAC_BITS;
	localparam int CB = nnds_pkg::COL_BITS;
	localparam int RB = nnds_pkg::ROW_BITS;

	logic [PW-1:0] col_pos_q;
	logic [PW-1:0] row_pos_q;
	logic [IW-1:0] in_col_q;
	logic [IW-1:0] in_row_q;
	logic [CB:0]   loc_q;
	logic [RB:0]   lor_q;
	logic          taken_q;
	logic          full_q;

	logic          row_start;
	logic [IW-1:0] iy;
	logic [IW-1:0] ix;
	logic          row_ok;
	logic          taken_eff;
	logic [RB:0]   lor_eff;
	logic [PW-1:0] col_base;
	logic [CB:0]   loc_base;
	logic          emit1;
	logic [CB:0]   loc_one;
	logic [CB:0]   loc_fin;
	logic          row_end;
	logic [IW:0]   in_col_inc;
	logic [IW:0]   in_row_inc;
	logic          pix_push;
	logic          fin_emit;
	logic [RB:0]   lor_inc;
	logic [RB:0]   lor_after;
	logic          fin_reset;

	always_comb begin
		row_start  = (in_col_q == '0);
		iy         = row_pos_q[PW-1:FRAC_BITS];
		row_ok     = (lor_q[RB] || 32'(lor_q[RB-1:0]) < 32'(iy))
			&& (lor_q[RB] || lor_q[RB-1:0] < hm1);
		taken_eff  = row_start ? row_ok : taken_q;
		lor_inc    = lor_q + 1'b1;
		lor_eff    = (row_start && row_ok) ? lor_inc : lor_q;
		col_base   = row_start ? '0 : col_pos_q;
		loc_base   = row_start ? '1 : loc_q;
		ix         = col_base[PW-1:FRAC_BITS];
		emit1      = (loc_base[CB] || 32'(loc_base[CB-1:0]) < 32'(ix))
			&& (loc_base[CB] || loc_base[CB-1:0] < wm1);
		loc_one    = emit1 ? loc_base + 1'b1 : loc_base;
		in_col_inc = {1'b0, in_col_q} + 1'b1;
		in_row_inc = {1'b0, in_row_q} + 1'b1;
		row_end    = (in_col_inc >= {1'b0, iw});
		if (row_end && (loc_one[CB] || loc_one[CB-1:0] < wm1)) begin
			loc_fin = {1'b0, wm1};
		end else begin
			loc_fin = loc_one;
		end
		pix_push   = !full_q && taken_eff && (loc_fin != loc_base);
		fin_emit   = lor_q[RB] || (lor_q[RB-1:0] < hm1);
		lor_after  = fin_emit ? lor_inc : lor_q;
		fin_reset  = !lor_after[RB] && (lor_after[RB-1:0] >= hm1);
	end

	always_comb begin
		cmd = '0;
		if (kind == nnds_pkg::KIND_FINISH) begin
			push           = accept && fin_emit;
			cmd.from_store = 1'b1;
			cmd.first_col  = '0;
			cmd.last_col   = wm1;
			cmd.row        = lor_inc[RB-1:0];
		end else begin
			push           = accept && pix_push;
			cmd.from_store = 1'b0;
			cmd.pix        = pixel_value;
			cmd.first_col  = loc_base[CB-1:0] + 1'b1;
			cmd.last_col   = loc_fin[CB-1:0];
			cmd.row        = lor_eff[RB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			loc_q     <= '1;
			lor_q     <= '1;
			taken_q   <= 1'b0;
			full_q    <= 1'b0;
		end else if (accept) begin
			if (kind == nnds_pkg::KIND_FINISH) begin
				if (fin_reset) begin
					col_pos_q <= '0;
					row_pos_q <= '0;
					in_col_q  <= '0;
					in_row_q  <= '0;
					loc_q     <= '1;
					lor_q     <= '1;
					taken_q   <= 1'b0;
					full_q    <= 1'b0;
				end else begin
					lor_q <= lor_after;
				end
			end else if (!full_q) begin
				col_pos_q <= col_base + PW'(step_x_eff);
				lor_q     <= lor_eff;
				loc_q     <= taken_eff ? loc_fin : loc_base;
				if (row_end) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_inc[IW-1:0];
					row_pos_q <= row_pos_q + PW'(step_y_eff);
					taken_q   <= 1'b0;
					if (in_row_inc >= {1'b0, ih}) begin
						full_q <= 1'b1;
					end
				end else begin
					in_col_q <= in_col_inc[IW-1:0];
					taken_q  <= taken_eff;
				end
			end
		end
	end

endmodule

// ----- rtl/nnds_queue.sv -----
// short command queue between the front and back parts
module nnds_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nnds_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output nnds_pkg::cmd_t head
);

	localparam int PB = nnds_pkg::QPTR_BITS;
	localparam int DEPTH = nnds_pkg::QUEUE_DEPTH;

	nnds_pkg::cmd_t entries_q [DEPTH];
	logic [PB-1:0]  wr_ptr_q;
	logic [PB-1:0]  rd_ptr_q;
	logic [PB:0]    count_q;

	assign full       = (count_q == (PB+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/nnds_back.sv -----
// back part: result sequencing, line store and output register
module nnds_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  nnds_pkg::cmd_t                head,
	output logic                          pop,
	input  logic [nnds_pkg::COL_BITS-1:0] wm1,
	input  logic [nnds_pkg::ROW_BITS-1:0] hm1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_pixel,
	output logic                          line_end,
	output logic                          frame_end,
	output logic                          last
);

	localparam int CB = nnds_pkg::COL_BITS;

	logic [7:0]     line_store_q [nnds_pkg::MAX_OUT_WIDTH];
	logic           busy_q;
	nnds_pkg::cmd_t work_q;
	logic [CB-1:0]  col_q;
	logic           valid_q;
	logic [7:0]     pix_q;
	logic [7:0]     rd_q;
	logic           sel_store_q;
	logic           line_end_q;
	logic           frame_end_q;
	logic           last_q;

	nnds_pkg::cmd_t cur;
	logic [CB-1:0]  col;
	logic           issue;
	logic           done;
	logic           le;

	always_comb begin
		cur   = busy_q ? work_q : head;
		col   = busy_q ? col_q : head.first_col;
		issue = (!valid_q || out_ready) && (busy_q || head_valid);
		done  = (col == cur.last_col);
		pop   = issue && !busy_q;
		le    = (col == wm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_q <= 1'b1;
				busy_q  <= !done;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (!busy_q) begin
				work_q <= head;
			end
			col_q       <= col + 1'b1;
			pix_q       <= cur.pix;
			sel_store_q <= cur.from_store;
			line_end_q  <= le;
			frame_end_q <= le && (cur.row == hm1);
			last_q      <= done;
			if (cur.from_store) begin
				rd_q <= line_store_q[col];
			end else begin
				line_store_q[col] <= cur.pix;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_pixel = sel_store_q ? rd_q : pix_q;
	assign line_end  = line_end_q;
	assign frame_end = frame_end_q;
	assign last      = last_q;

endmodule

// ----- rtl/nearest_neighbour_downscaler_unit.sv -----
// top level of the nearest-neighbour downscaler with its register file
//
// usage
//  - slave stream: one transfer per input pixel in raster order, s_tuser = 0,
//    s_tdata = palette index; a transfer with s_tuser = 1 finishes the image
//    and repeats the kept row for a missing final output row
//  - master stream: output pixels, m_tlast on the last pixel of the image,
//    m_tuser flags the end of an output row and the last result of an input
//  - the user must write registers over the apb port only while idle; unchecked
//  - one input transfer per cycle is taken while the command queue has room;
//    the back part sends one result per cycle while the receiver is ready; an
//    input that makes several results (row padding, finish) keeps it busy
//  - an input that makes no result sends nothing; with the back part idle, an
//    input's first result reaches m_tvalid through the queue and the output register
//  - a stalled receiver holds the output register, the queue fills and then
//    s_tready drops
//  - reset restores register defaults and the image state; the line store
//    keeps no reset value and is filled by the rows it repeats
module nearest_neighbour_downscaler_unit #(
	parameter int MAX_IN_SIZE = nnds_pkg::DEF_MAX_IN_SIZE,
	parameter int FRAC_BITS   = nnds_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // pixel_value
	input  logic                           s_tuser,   // kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // out_pixel
	output logic [1:0]                     m_tuser,   // line_end, last
	output logic                           m_tlast,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nnds_pkg::ADDR_BITS-1:0] paddr,
	input  logic [nnds_pkg::DATA_BITS-1:0] pwdata,
	output logic [nnds_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);

	localparam int IW  = $clog2(MAX_IN_SIZE + 1);
	localparam int SW  = FRAC_BITS + 1;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int CB  = nnds_pkg::COL_BITS;
	localparam int RB  = nnds_pkg::ROW_BITS;
	localparam int DW  = nnds_pkg::DATA_BITS;

	logic [16:0] step_x_q;
	logic [16:0] step_y_q;
	logic [12:0] in_width_q;
	logic [12:0] in_height_q;
	logic [6:0]  out_width_q;
	logic [6:0]  out_height_q;

	logic           wr_en;
	logic [2:0]     reg_idx;
	logic [SW-1:0]  step_x_eff;
	logic [SW-1:0]  step_y_eff;
	logic [IW-1:0]  iw;
	logic [IW-1:0]  ih;
	logic [CB-1:0]  wm1;
	logic [RB-1:0]  hm1;

	logic           accept;
	logic           push;
	nnds_pkg::cmd_t push_cmd;
	logic           pop;
	logic           q_full;
	logic           head_valid;
	nnds_pkg::cmd_t head;
	logic           line_end;
	logic           last;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q     <= 17'd32768;
			step_y_q     <= 17'd32768;
			in_width_q   <= 13'd1;
			in_height_q  <= 13'd1;
			out_width_q  <= 7'd50;
			out_height_q <= 7'd50;
		end else if (wr_en) begin
			unique case (reg_idx)
				nnds_pkg::REG_STEP_X:     step_x_q     <= pwdata[16:0];
				nnds_pkg::REG_STEP_Y:     step_y_q     <= pwdata[16:0];
				nnds_pkg::REG_IN_WIDTH:   in_width_q   <= pwdata[12:0];
				nnds_pkg::REG_IN_HEIGHT:  in_height_q  <= pwdata[12:0];
				nnds_pkg::REG_OUT_WIDTH:  out_width_q  <= pwdata[6:0];
				nnds_pkg::REG_OUT_HEIGHT: out_height_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			nnds_pkg::REG_STEP_X:     prdata = DW'(step_x_q);
			nnds_pkg::REG_STEP_Y:     prdata = DW'(step_y_q);
			nnds_pkg::REG_IN_WIDTH:   prdata = DW'(in_width_q);
			nnds_pkg::REG_IN_HEIGHT:  prdata = DW'(in_height_q);
			nnds_pkg::REG_OUT_WIDTH:  prdata = DW'(out_width_q);
			nnds_pkg::REG_OUT_HEIGHT: prdata = DW'(out_height_q);
			default:                  prdata = '0;
		endcase
	end

	// clamped working values
	always_comb begin
		step_x_eff = (32'(step_x_q) > ONE) ? SW'(ONE) : SW'(step_x_q);
		step_y_eff = (32'(step_y_q) > ONE) ? SW'(ONE) : SW'(step_y_q);

		if (in_width_q == '0) begin
			iw = IW'(1);
		end else if (32'(in_width_q) > MAX_IN_SIZE) begin
			iw = IW'(MAX_IN_SIZE);
		end else begin
			iw = IW'(in_width_q);
		end

		if (in_height_q == '0) begin
			ih = IW'(1);
		end else if (32'(in_height_q) > MAX_IN_SIZE) begin
			ih = IW'(MAX_IN_SIZE);
		end else begin
			ih = IW'(in_height_q);
		end

		if (out_width_q == '0) begin
			wm1 = '0;
		end else if (32'(out_width_q) > nnds_pkg::MAX_OUT_WIDTH) begin
			wm1 = CB'(nnds_pkg::MAX_OUT_WIDTH - 1);
		end else begin
			wm1 = CB'(out_width_q - 7'd1);
		end

		if (out_height_q == '0) begin
			hm1 = '0;
		end else if (32'(out_height_q) > nnds_pkg::OUT_HEIGHT_MAX) begin
			hm1 = RB'(nnds_pkg::OUT_HEIGHT_MAX - 1);
		end else begin
			hm1 = RB'(out_height_q - 7'd1);
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	nnds_front #(
		.MAX_IN_SIZE (MAX_IN_SIZE),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (s_tuser),
		.pixel_value (s_tdata),
		.step_x_eff  (step_x_eff),
		.step_y_eff  (step_y_eff),
		.iw          (iw),
		.ih          (ih),
		.wm1         (wm1),
		.hm1         (hm1),
		.push        (push),
		.cmd         (push_cmd)
	);

	nnds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	nnds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.wm1        (wm1),
		.hm1        (hm1),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pixel  (m_tdata),
		.line_end   (line_end),
		.frame_end  (m_tlast),
		.last       (last)
	);

	assign m_tuser = {last, line_end};

endmodule
